FILE: rtl/cb64_pkg.sv
// Shared types, constants and the base64 alphabet for the chunked base64 encoder.
`default_nettype none

package cb64_pkg;

    localparam int unsigned CHUNK_W = 13;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd384;
    localparam logic [CHAR_W-1:0]  PAD_CHAR    = 7'd61;
    localparam logic [CHAR_W-1:0]  LINE_FEED   = 7'd10;

    // Slot index within one encoding job: four group characters, then the line feed.
    localparam logic [2:0] SLOT_LAST_CHAR = 3'd3;
    localparam logic [2:0] SLOT_LF        = 3'd4;

    // One encoding job handed from the front to the back.
    typedef struct packed {
        logic [23:0] group;    // oldest byte in the high bits
        logic [2:0]  nvalid;   // characters taken from the group (2, 3 or 4)
        logic        with_lf;  // a line feed follows the four characters
        logic        pend;     // the line feed closes the payload
    } job_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] idx);
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] idx7;
        idx7 = {1'b0, idx};
        if (idx < 6'd26)
            ch = 7'd65 + idx7;
        else if (idx < 6'd52)
            ch = 7'd97 + idx7 - 7'd26;
        else if (idx < 6'd62)
            ch = 7'd48 + idx7 - 7'd52;
        else if (idx == 6'd62)
            ch = 7'd43;
        else
            ch = 7'd47;
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cb64_front.sv
// Front end: takes bytes, tracks group and chunk fill, and issues encoding jobs.
`default_nettype none

module cb64_front
    import cb64_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr,
    input  wire logic [CHUNK_W-1:0] cfg_data,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output logic                    job_valid,
    output job_t                    job
);

    logic [CHUNK_W-1:0] chunk_bytes_reg;
    logic [CHUNK_W-1:0] chunk_fill_reg;
    logic [CHUNK_W-1:0] chunk_fill_next;
    logic [15:0]        pending_reg;
    logic [15:0]        pending_next;
    logic [1:0]         group_fill_reg;
    logic [1:0]         group_fill_next;

    logic [CHUNK_W-1:0] limit;
    logic [CHUNK_W-1:0] fill_inc;
    logic [15:0]        shifted;
    logic               group_full;
    logic               chunk_done;

    always_comb
    begin
        limit      = (chunk_bytes_reg == '0) ? CHUNK_W'(1) : chunk_bytes_reg;
        fill_inc   = chunk_fill_reg + CHUNK_W'(1);
        chunk_done = last_byte || (fill_inc >= limit);
        group_full = (group_fill_reg == 2'd2);
        shifted    = {pending_reg[7:0], data_byte};

        job.pend    = last_byte;
        job.with_lf = chunk_done;
        if (group_full)
        begin
            job.group  = {pending_reg, data_byte};
            job.nvalid = 3'd4;
        end
        else if (group_fill_reg == 2'd1)
        begin
            // Second byte of a group: only a chunk end turns it into a padded group.
            job.group  = {shifted, 8'd0};
            job.nvalid = 3'd3;
        end
        else
        begin
            job.group  = {data_byte, 16'd0};
            job.nvalid = 3'd2;
        end
        job_valid = accept && (group_full || chunk_done);

        chunk_fill_next = chunk_fill_reg;
        pending_next    = pending_reg;
        group_fill_next = group_fill_reg;
        if (accept)
        begin
            if (chunk_done)
            begin
                chunk_fill_next = '0;
                pending_next    = '0;
                group_fill_next = 2'd0;
            end
            else
            begin
                chunk_fill_next = fill_inc;
                if (group_full)
                begin
                    pending_next    = '0;
                    group_fill_next = 2'd0;
                end
                else
                begin
                    pending_next    = shifted;
                    group_fill_next = group_fill_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bytes_reg <= CHUNK_RESET;
            chunk_fill_reg  <= '0;
            pending_reg     <= '0;
            group_fill_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr)
                chunk_bytes_reg <= cfg_data;
            chunk_fill_reg <= chunk_fill_next;
            pending_reg    <= pending_next;
            group_fill_reg <= group_fill_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cb64_queue.sv
// Short job queue between the front end and the character sequencer.
`default_nettype none

module cb64_queue
    import cb64_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      full,
    input  wire logic rd_en,
    output logic      nonempty,
    output job_t      rd_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    always_comb
    begin
        full     = (count_reg == CNT_FULL);
        nonempty = (count_reg != '0);
        do_wr    = wr_en && !full;
        do_rd    = rd_en && nonempty;
        rd_job   = entries[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cb64_back.sv
// Back end: walks each job, one character per cycle, while the output register is empty or popped.
`default_nettype none

module cb64_back
    import cb64_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              job_ready,
    input  wire job_t              job_in,
    output logic                   job_take,
    input  wire logic              pop,
    output logic                   empty,
    output logic [CHAR_W-1:0]      out_char,
    output logic                   run_end,
    output logic                   payload_end
);

    job_t              job_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [2:0]        slot_reg;
    logic [2:0]        slot_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [CHAR_W-1:0] char_reg;
    logic              run_end_reg;
    logic              pend_reg;

    logic              advance;
    logic              slot_last;
    logic [5:0]        sextet;
    logic [CHAR_W-1:0] char_now;

    always_comb
    begin
        advance   = busy_reg && (!out_valid_reg || pop);
        slot_last = job_reg.with_lf ? (slot_reg == SLOT_LF) : (slot_reg == SLOT_LAST_CHAR);
        case (slot_reg[1:0])
            2'd0:    sextet = job_reg.group[23:18];
            2'd1:    sextet = job_reg.group[17:12];
            2'd2:    sextet = job_reg.group[11:6];
            default: sextet = job_reg.group[5:0];
        endcase
        if (slot_reg == SLOT_LF)
            char_now = LINE_FEED;
        else if (slot_reg < job_reg.nvalid)
            char_now = b64_char(sextet);
        else
            char_now = PAD_CHAR;

        // A new job loads when the sequencer is free or emits its final character now.
        job_take = job_ready && (!busy_reg || (advance && slot_last));

        busy_next = busy_reg;
        slot_next = slot_reg;
        if (job_take)
        begin
            busy_next = 1'b1;
            slot_next = 3'd0;
        end
        else if (advance)
        begin
            if (slot_last)
                busy_next = 1'b0;
            slot_next = slot_reg + 3'd1;
        end

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            slot_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
            job_reg <= job_in;
        if (advance)
        begin
            char_reg    <= char_now;
            run_end_reg <= slot_last;
            pend_reg    <= (slot_reg == SLOT_LF) && job_reg.pend;
        end
    end

    assign empty       = !out_valid_reg;
    assign out_char    = char_reg;
    assign run_end     = run_end_reg;
    assign payload_end = pend_reg;

endmodule

`default_nettype wire

FILE: rtl/chunked_base64_encoder.sv
// Top level of the chunked base64 encoder.
`default_nettype none

// Bytes enter through push/full and base64 text leaves one character per
// item through empty/pop. A byte is taken in any cycle in which the job
// queue has room, so bytes that only add to a group go at one per cycle.
// A byte that closes a group gives four characters, and one that closes a
// chunk or the payload gives four characters and a line feed; the character
// sequencer drives one character per cycle while its output is empty or
// popped. With the sequencer idle, a job is written to the queue, loaded
// into the sequencer and its first character registered for output.
// The user must write the chunk size register through chunk_bytes_wr only
// while the block is idle; the block itself does not enforce this. A value
// of zero behaves as one byte per chunk.

module chunked_base64_encoder
    import cb64_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               chunk_bytes_wr,
    input  wire logic [CHUNK_W-1:0] chunk_bytes,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire logic               pop,
    output logic                    empty,
    output logic [CHAR_W-1:0]       out_char,
    output logic                    run_end,
    output logic                    payload_end
);

    logic accept;
    logic job_valid;
    job_t job_front;
    logic job_ready;
    job_t job_back;
    logic job_take;

    assign accept = push && !full;

    cb64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (chunk_bytes_wr),
        .cfg_data  (chunk_bytes),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .job_valid (job_valid),
        .job       (job_front)
    );

    cb64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_valid),
        .wr_job   (job_front),
        .full     (full),
        .rd_en    (job_take),
        .nonempty (job_ready),
        .rd_job   (job_back)
    );

    cb64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_ready   (job_ready),
        .job_in      (job_back),
        .job_take    (job_take),
        .pop         (pop),
        .empty       (empty),
        .out_char    (out_char),
        .run_end     (run_end),
        .payload_end (payload_end)
    );

endmodule

`default_nettype wire
